FILE: src/ppsc_pkg.sv
// Package: shared widths, sequencer states and the arctangent table for the steering block.
`default_nettype none
package ppsc_pkg;
   localparam int MulAW   = 24;   // multiplicand width
   localparam int MulBW   = 18;   // multiplier width, one bit per cycle
   localparam int MulPW   = MulAW + MulBW;
   localparam int CordW   = 58;
   localparam int ZW      = 25;
   localparam int PreviewIndex = 15;
   localparam logic [13:0] SteerMax   = 14'd5000;
   localparam logic [13:0] SteerSharp = 14'd4000;
   localparam logic [14:0] HoldLimit  = 15'd1089;
   localparam logic [14:0] HoldSpeed  = 15'd1100;
   localparam logic [15:0] SnapLow    = 16'sd50;
   localparam logic [15:0] SnapHigh   = 16'sd100;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_SQX, ST_SQY, ST_LIM, ST_NUM, ST_CINIT,
      ST_CORD, ST_SSTART, ST_SCALE, ST_FIN
   } state_type;

   typedef struct packed {
      logic             start;
      logic [MulAW-1:0] a;
      logic [MulBW-1:0] b;
   } mul_req_type;

   function automatic logic [22:0] atan_step(input logic [3:0] i);
      unique case (i)
         4'd0:  atan_step = 23'd2949120;
         4'd1:  atan_step = 23'd1740967;
         4'd2:  atan_step = 23'd919879;
         4'd3:  atan_step = 23'd466945;
         4'd4:  atan_step = 23'd234379;
         4'd5:  atan_step = 23'd117304;
         4'd6:  atan_step = 23'd58666;
         4'd7:  atan_step = 23'd29335;
         4'd8:  atan_step = 23'd14668;
         4'd9:  atan_step = 23'd7334;
         4'd10: atan_step = 23'd3667;
         4'd11: atan_step = 23'd1833;
         4'd12: atan_step = 23'd917;
         4'd13: atan_step = 23'd458;
         4'd14: atan_step = 23'd229;
         default: atan_step = 23'd115;
      endcase
   endfunction
endpackage
`default_nettype wire

FILE: src/ppsc_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module ppsc_smul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ppsc_pkg::mul_req_type      req,
   output logic                            done,
   output logic [ppsc_pkg::MulPW-1:0]      product
);
   import ppsc_pkg::*;

   logic [MulPW-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [MulBW-1:0] b_ff, b_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         a_in    = {{MulBW{1'b0}}, req.a};
         b_in    = req.b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in   = {a_ff[MulPW-2:0], 1'b0};
         b_in   = {1'b0, b_ff[MulBW-1:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(MulBW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: src/preview_point_steering_command_top.sv
// Top level: preview-point steering command sequencer with serial multiplier and CORDIC.
//  channel | ports          | direction | handshake
//  request | req_*          | in        | req_valid / req_ready
//  result  | rsp_*          | out       | rsp_valid / rsp_ready
//  config  | csr_*          | in        | csr_we, no wait
// A driving tick runs five serial multiplies, each stepping through the 18 multiplier
// bits, and 16 CORDIC iterations; the radius clamp skips one multiply. Brake and
// straight ticks skip the multiplies and CORDIC and go from the decision state
// to the result stage; the block returns to idle once the result is registered.
// All multiplies share the single bit-serial multiplier.
// Reset loads the config registers with their defaults, clears the command state and empties the result register.
// A stalled result holds; the next item is taken while it waits.
`default_nettype none
module preview_point_steering_command_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_preview_x,
   input  wire logic signed [15:0] req_preview_y,
   input  wire logic signed [15:0] req_speed_ref,
   input  wire logic [15:0]        req_collision_time,
   input  wire logic [9:0]         req_path_points,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [13:0]      rsp_steering_angle,
   output logic [14:0]             rsp_dest_speed,
   output logic [14:0]             rsp_prior_speed,
   output logic                    rsp_emergency_brake,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import ppsc_pkg::*;

   localparam logic [1:0] RegMinRadius = 2'd0;
   localparam logic [1:0] RegWheelBase = 2'd1;
   localparam logic [1:0] RegSteerRat  = 2'd2;
   localparam logic [1:0] RegMinCtime  = 2'd3;

   logic [12:0] mtr_ff;
   logic [9:0]  wb_ff;
   logic [13:0] sr_ff;
   logic [15:0] mct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtr_ff <= 13'd500;
         wb_ff  <= 10'd280;
         sr_ff  <= 14'd4096;
         mct_ff <= 16'd2000;
      end else if (csr_we) begin
         unique case (csr_index)
            RegMinRadius: mtr_ff <= csr_wdata[12:0];
            RegWheelBase: wb_ff  <= csr_wdata[9:0];
            RegSteerRat:  sr_ff  <= csr_wdata[13:0];
            RegMinCtime:  mct_ff <= csr_wdata;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic signed [15:0] x_ff, y_ff, vref_ff;
   logic [15:0] ct_ff;
   logic [9:0]  np_ff;
   logic [31:0] d2_ff, d2_in;
   logic [31:0] den_ff, den_in;
   logic [26:0] num_ff, num_in;
   logic signed [CordW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [3:0]  it_ff, it_in;
   logic        brake_ff, brake_in;
   logic [13:0] mag_ff, mag_in;
   logic [14:0] speed_ff, speed_in, prior_ff, prior_in;
   logic signed [13:0] steer_ff, steer_in;
   logic        rv_ff, rv_in;
   logic signed [13:0] ro_steer_ff, ro_steer_in;
   logic [14:0] ro_speed_ff, ro_speed_in, ro_prior_ff, ro_prior_in;
   logic        ro_brake_ff, ro_brake_in;

   mul_req_type      mreq;
   logic             mdone;
   logic [MulPW-1:0] mprod;

   ppsc_smul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .product(mprod));

   logic [16:0] ax, ay;
   logic [17:0] ay2;
   logic signed [CordW-1:0] dx, dy;
   logic [23:0] zpos;
   logic [17:0] sr10;
   logic [42:0] rnd;
   logic [14:0] snap;
   logic [14:0] held;
   logic        accept;

   always_comb begin
      ax   = x_ff[15] ? 17'(-{x_ff[15], x_ff}) : {1'b0, x_ff};
      ay   = y_ff[15] ? 17'(-{y_ff[15], y_ff}) : {1'b0, y_ff};
      ay2  = {ay, 1'b0};
      dx   = cy_ff >>> it_ff;
      dy   = cx_ff >>> it_ff;
      zpos = z_ff[ZW-1] ? 24'd0 : z_ff[23:0];
      sr10 = 18'({sr_ff, 3'b000}) + 18'({sr_ff, 1'b0});
      rnd  = {1'b0, mprod} + 43'd8388608;
      if (vref_ff < $signed(SnapLow)) snap = '0;
      else if (vref_ff <= $signed(SnapHigh)) snap = 15'd100;
      else snap = vref_ff[14:0];
      held = (speed_ff <= HoldLimit && mag_ff >= SteerSharp) ? HoldSpeed : speed_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      d2_in = d2_ff; den_in = den_ff; num_in = num_ff;
      cx_in = cx_ff; cy_in = cy_ff; z_in = z_ff; it_in = it_ff;
      brake_in = brake_ff; mag_in = mag_ff;
      speed_in = speed_ff; prior_in = prior_ff; steer_in = steer_ff;
      rv_in = rv_ff && !rsp_ready;
      ro_steer_in = ro_steer_ff; ro_speed_in = ro_speed_ff;
      ro_prior_in = ro_prior_ff; ro_brake_in = ro_brake_ff;
      mreq = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            mag_in = '0;
            if (!(ct_ff > mct_ff && np_ff > 10'(PreviewIndex))) begin
               brake_in = 1'b1;
               state_in = ST_FIN;
            end else if (y_ff == 16'sd0 || wb_ff == 10'd0) begin
               brake_in = 1'b0;
               state_in = ST_FIN;
            end else begin
               brake_in = 1'b0;
               mreq = '{start: 1'b1, a: 24'(ax), b: 18'(ax)};
               state_in = ST_SQX;
            end
         end
         ST_SQX: if (mdone) begin
            d2_in = mprod[31:0];
            mreq = '{start: 1'b1, a: 24'(ay), b: 18'(ay)};
            state_in = ST_SQY;
         end
         ST_SQY: if (mdone) begin
            d2_in = d2_ff + mprod[31:0];
            mreq = '{start: 1'b1, a: 24'(mtr_ff), b: ay2};
            state_in = ST_LIM;
         end
         ST_LIM: if (mdone) begin
            if ({{(MulPW-32){1'b0}}, d2_ff} < mprod) begin
               num_in = 27'(wb_ff);
               den_in = 32'(mtr_ff);
               state_in = ST_CINIT;
            end else begin
               mreq = '{start: 1'b1, a: 24'(wb_ff), b: ay2};
               state_in = ST_NUM;
            end
         end
         ST_NUM: if (mdone) begin
            num_in = mprod[26:0];
            den_in = d2_ff;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            cx_in = CordW'({den_ff, 24'd0});
            cy_in = CordW'({num_ff, 24'd0});
            z_in  = '0;
            it_in = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               z_in  = z_ff + ZW'(atan_step(it_ff));
            end else begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               z_in  = z_ff - ZW'(atan_step(it_ff));
            end
            it_in = it_ff + 4'd1;
            if (it_ff == 4'd15) state_in = ST_SSTART;
         end
         ST_SSTART: begin
            mreq = '{start: 1'b1, a: zpos, b: sr10};
            state_in = ST_SCALE;
         end
         ST_SCALE: if (mdone) begin
            mag_in = (rnd[42:24] > 19'(SteerMax)) ? SteerMax : rnd[37:24];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               ro_brake_in = brake_ff;
               if (brake_ff) begin
                  speed_in = '0;
                  ro_steer_in = steer_ff;
                  ro_prior_in = prior_ff;
               end else begin
                  steer_in = y_ff[15] ? 14'(-mag_ff) : mag_ff;
                  ro_steer_in = steer_in;
                  if (held != snap) prior_in = held;
                  ro_prior_in = prior_in;
                  speed_in = snap;
               end
               ro_speed_in = speed_in;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         speed_ff <= '0;
         prior_ff <= '0;
         steer_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         speed_ff <= speed_in;
         prior_ff <= prior_in;
         steer_ff <= steer_in;
      end
      if (accept) begin
         x_ff <= req_preview_x;
         y_ff <= req_preview_y;
         vref_ff <= req_speed_ref;
         ct_ff <= req_collision_time;
         np_ff <= req_path_points;
      end
      d2_ff <= d2_in; den_ff <= den_in; num_ff <= num_in;
      cx_ff <= cx_in; cy_ff <= cy_in; z_ff <= z_in; it_ff <= it_in;
      brake_ff <= brake_in; mag_ff <= mag_in;
      ro_steer_ff <= ro_steer_in; ro_speed_ff <= ro_speed_in;
      ro_prior_ff <= ro_prior_in; ro_brake_ff <= ro_brake_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_steering_angle  = ro_steer_ff;
   assign rsp_dest_speed      = ro_speed_ff;
   assign rsp_prior_speed     = ro_prior_ff;
   assign rsp_emergency_brake = ro_brake_ff;

   // multiplier finishes only while the sequencer waits for it
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mdone |-> (state_ff == ST_SQX || state_ff == ST_SQY || state_ff == ST_LIM ||
                 state_ff == ST_NUM || state_ff == ST_SCALE))
      else $error("multiplier done outside a multiply state");
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (ro_steer_ff <= 14'sd5000 && ro_steer_ff >= -14'sd5000))
      else $error("steering out of range");
   a_brake_stop: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && ro_brake_ff) |-> (ro_speed_ff == 15'd0))
      else $error("brake with nonzero speed");
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the preview-point steering block: table-driven and random ticks checked against a local model.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ppsc_pkg::*;

   typedef enum logic [1:0] {
      CSR_MIN_RADIUS = 2'd0, CSR_WHEEL_BASE = 2'd1, CSR_STEER_RATIO = 2'd2, CSR_MIN_CTIME = 2'd3
   } csr_reg_type;

   typedef struct {
      logic signed [15:0] x, y, vref;
      logic [15:0]        ctime;
      logic [9:0]         npts;
      bit                 typed;
      logic signed [13:0] steer;
      logic [14:0]        speed, prior;
      logic               brake;
   } tick_row_type;

   typedef struct packed {
      logic signed [13:0] steer;
      logic [14:0]        speed, prior;
      logic               brake;
   } command_type;

   localparam longint AtanDegQ16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_emergency_brake, csr_we;
   logic signed [15:0] req_preview_x, req_preview_y, req_speed_ref;
   logic [15:0] req_collision_time, csr_wdata;
   logic [9:0] req_path_points;
   logic signed [13:0] rsp_steering_angle;
   logic [14:0] rsp_dest_speed, rsp_prior_speed;
   logic [1:0] csr_index;

   preview_point_steering_command_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // model state and register copies
   longint unsigned min_radius, wbase_cfg, ratio_cfg, min_ctime;
   logic [14:0] speed_q, prior_q;
   logic signed [13:0] steer_q;
   command_type expected_q[$];
   int errors = 0;
   bit calm = 1'b0, hold_start = 1'b0, hold_done = 1'b0;
   int hold_left = 0;

   function automatic longint atan_deg(longint unsigned num, longint unsigned den);
      longint cx, cy, z, dx, dy;
      if (num == 0) return 0;
      cx = longint'(den << 24);
      cy = longint'(num << 24);
      z = 0;
      for (int i = 0; i < 16; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx += dx; cy -= dy; z += AtanDegQ16[i];
         end else begin
            cx -= dx; cy += dy; z -= AtanDegQ16[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic int steer_tenths(longint x, longint y);
      longint unsigned ay, d2, num, den, mag;
      if (y == 0 || wbase_cfg == 0) return 0;
      ay = (y < 0) ? -y : y;
      d2 = x * x + ay * ay;
      if (d2 < min_radius * 2 * ay) begin
         num = wbase_cfg; den = min_radius;
      end else begin
         num = 2 * wbase_cfg * ay; den = d2;
      end
      mag = (longint'(atan_deg(num, den)) * ratio_cfg * 10 + (64'd1 << 23)) >> 24;
      if (mag > 5000) mag = 5000;
      return (y < 0) ? -int'(mag) : int'(mag);
   endfunction

   function automatic command_type next_command(tick_row_type t);
      command_type c;
      int st;
      logic [14:0] prev, nxt;
      if (t.ctime > min_ctime && t.npts > PreviewIndex) begin
         st = steer_tenths(t.x, t.y);
         steer_q = st[13:0];
         if (speed_q <= 1089 && (st >= 4000 || st <= -4000)) speed_q = 15'd1100;
         prev = speed_q;
         if (t.vref < 50) nxt = 0;
         else if (t.vref <= 100) nxt = 15'd100;
         else nxt = t.vref[14:0];
         if (prev != nxt) prior_q = prev;
         speed_q = nxt;
         c.brake = 1'b0;
      end else begin
         speed_q = 0;
         c.brake = 1'b1;
      end
      c.steer = steer_q; c.speed = speed_q; c.prior = prior_q;
      return c;
   endfunction

   task automatic send_tick(tick_row_type t);
      command_type c;
      req_valid <= 1'b1;
      req_preview_x <= t.x; req_preview_y <= t.y; req_speed_ref <= t.vref;
      req_collision_time <= t.ctime; req_path_points <= t.npts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      c = next_command(t);
      if (t.typed) begin
         c.steer = t.steer; c.speed = t.speed; c.prior = t.prior; c.brake = t.brake;
      end
      expected_q.insert(expected_q.size(), c);
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_csr(csr_reg_type r, logic [15:0] v);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);   // a brake tick may still be in flight
      csr_we <= 1'b1; csr_index <= r; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (r)
         CSR_MIN_RADIUS:  min_radius = v[12:0];
         CSR_WHEEL_BASE:  wbase_cfg  = v[9:0];
         CSR_STEER_RATIO: ratio_cfg  = v[13:0];
         CSR_MIN_CTIME:   min_ctime  = v;
      endcase
   endtask

   task automatic random_ticks(int n);
      tick_row_type t;
      int m;
      for (int i = 0; i < n; i++) begin
         m = $urandom_range(99);
         t.typed = 1'b0;
         t.x = $urandom; t.y = $urandom; t.vref = $urandom;
         t.ctime = $urandom; t.npts = $urandom;
         if (m < 85 && min_ctime < 65535) begin
            t.ctime = $urandom_range(65535, min_ctime + 1);
            t.npts = $urandom_range(1023, PreviewIndex + 1);
            case ($urandom_range(3))
               0: begin t.x = $urandom_range(4000) - 2000; t.y = $urandom_range(4000) - 2000; end
               1: begin t.x = $urandom_range(600) - 300; t.y = $urandom_range(100) - 50; end
               default: ;
            endcase
            case ($urandom_range(3))
               0: t.vref = $urandom_range(210) - 10;
               1: t.vref = $urandom_range(1200, 1000);
               default: ;
            endcase
         end
         send_tick(t);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_start && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 600;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      command_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer: steer %0d", rsp_steering_angle);
         end else begin
            e = expected_q.pop_front();
            if (rsp_steering_angle !== e.steer || rsp_dest_speed !== e.speed ||
                rsp_prior_speed !== e.prior || rsp_emergency_brake !== e.brake) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     e.steer, e.speed, e.prior, e.brake, rsp_steering_angle,
                     rsp_dest_speed, rsp_prior_speed, rsp_emergency_brake);
            end
         end
      end
   end

   tick_row_type directed [15] = '{
      // x, y, vref, ctime, npts, typed, steer, speed, prior, brake
      '{16'sd100, 16'sd100, 16'sd500, 16'd0, 10'd500, 1, 14'sd0, 15'd0, 15'd0, 1'b1},
      '{16'sd100, 16'sd100, 16'sd500, 16'd65535, 10'd15, 1, 14'sd0, 15'd0, 15'd0, 1'b1},
      '{16'sd100, 16'sd100, 16'sd500, 16'd2000, 10'd1023, 1, 14'sd0, 15'd0, 15'd0, 1'b1},
      '{16'sd3000, 16'sd0, 16'sd5000, 16'd2001, 10'd16, 1, 14'sd0, 15'd5000, 15'd0, 1'b0},
      '{16'sd0, 16'sd0, 16'sd32767, 16'd65535, 10'd1023, 1, 14'sd0, 15'd32767, 15'd5000, 1'b0},
      '{16'sd32767, -16'sd32768, 16'sd49, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{-16'sd32768, 16'sd32767, 16'sd50, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd0, 16'sd1, 16'sd100, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd0, -16'sd1, 16'sd101, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd20, 16'sd400, 16'sd1000, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd20, -16'sd400, 16'sd1000, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd500, 16'sd50, -16'sd32768, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd5, 16'sd2, 16'sd1089, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{16'sd5, 16'sd2, 16'sd1089, 16'd9000, 10'd100, 0, 0, 0, 0, 0},
      '{-16'sd1, -16'sd1, 16'sd0, 16'd9000, 10'd100, 0, 0, 0, 0, 0}
   };

   initial begin
      min_radius = 500; wbase_cfg = 280; ratio_cfg = 4096; min_ctime = 2000;
      speed_q = 0; prior_q = 0; steer_q = 0;
      req_valid <= 1'b0; req_preview_x <= 0; req_preview_y <= 0; req_speed_ref <= 0;
      req_collision_time <= 0; req_path_points <= 0;
      csr_we <= 1'b0; csr_index <= CSR_MIN_RADIUS; csr_wdata <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_tick(directed[i]);
      random_ticks(400);
      write_csr(CSR_MIN_RADIUS, 16'd5000);
      write_csr(CSR_WHEEL_BASE, 16'd1000);
      write_csr(CSR_STEER_RATIO, 16'd8192);
      write_csr(CSR_MIN_CTIME, 16'd0);
      calm = 1'b1;
      random_ticks(300);
      calm = 1'b0;
      write_csr(CSR_MIN_RADIUS, 16'd100);
      write_csr(CSR_WHEEL_BASE, 16'd50);
      write_csr(CSR_STEER_RATIO, 16'd256);
      write_csr(CSR_MIN_CTIME, 16'd65535);
      random_ticks(100);
      write_csr(CSR_MIN_RADIUS, 16'd0);
      write_csr(CSR_WHEEL_BASE, 16'd0);
      write_csr(CSR_STEER_RATIO, 16'd16383);
      write_csr(CSR_MIN_CTIME, 16'd100);
      random_ticks(150);
      write_csr(CSR_WHEEL_BASE, 16'd1023);
      write_csr(CSR_MIN_RADIUS, 16'd8191);
      random_ticks(300);
      write_csr(CSR_MIN_RADIUS, 16'd500);
      write_csr(CSR_WHEEL_BASE, 16'd280);
      write_csr(CSR_STEER_RATIO, 16'd4096);
      write_csr(CSR_MIN_CTIME, 16'd2000);
      hold_start <= 1'b1;   // receiver stops while ticks keep coming
      random_ticks(400);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

FILE: preview_point_steering_command_top.f
src/ppsc_pkg.sv
src/ppsc_smul.sv
src/preview_point_steering_command_top.sv
sim/tb_top.sv
